// File: src/saz_pkg.sv
// saz_pkg: shared types, codes and reset values for the startup auto-zero sequencer
// used by every file in src; depends on nothing

package saz_pkg;

   localparam int MASS_W        = 64;
   localparam int MASS_BITS_DEF = 64;
   localparam int TIME_W        = 32;

   // phase codes
   localparam logic [3:0] PH_WAIT_MEAS   = 4'd0;
   localparam logic [3:0] PH_WAIT_STABLE = 4'd1;
   localparam logic [3:0] PH_DISABLED    = 4'd2;
   localparam logic [3:0] PH_TARE        = 4'd3;
   localparam logic [3:0] PH_FAULT       = 4'd4;
   localparam logic [3:0] PH_BADCAL      = 4'd5;
   localparam logic [3:0] PH_TIMEOUT     = 4'd6;
   localparam logic [3:0] PH_RANGE       = 4'd7;
   localparam logic [3:0] PH_APPLIED     = 4'd8;

   // op codes
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   // completion codes
   localparam logic [1:0] ZR_OK      = 2'd0;
   localparam logic [1:0] ZR_RANGE   = 2'd1;
   localparam logic [1:0] ZR_BADCAL  = 2'd2;
   localparam logic [1:0] ZR_FAILURE = 2'd3;
   localparam logic [2:0] LAST_NONE  = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_ENABLED    = 2'd0;
   localparam logic [1:0] CSR_TARE       = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd2;
   localparam logic [1:0] CSR_ZERO_RANGE = 2'd3;

   localparam logic [TIME_W-1:0] TIMEOUT_DEF = 32'd5000;

   typedef struct packed {
      logic                     boot_enable;
      logic                     tare_restored;
      logic [TIME_W-1:0]        timeout_lim;
      logic signed [MASS_W-1:0] zero_range;
   } saz_cfg_type;

   typedef struct packed {
      logic        reinit;
      saz_cfg_type next;
   } saz_load_type;

   typedef struct packed {
      logic                     op;
      logic [TIME_W-1:0]        now_ms;
      logic                     app_live;
      logic                     front_fault;
      logic                     cal_ok;
      logic                     meas_ready;
      logic                     stable;
      logic signed [MASS_W-1:0] gross_mass;
      logic [1:0]               zero_result;
   } saz_req_type;

   typedef struct packed {
      logic                     zero_request;
      logic [3:0]               phase;
      logic                     is_terminal;
      logic                     request_pending;
      logic [TIME_W-1:0]        elapsed;
      logic signed [MASS_W-1:0] observed_mass;
      logic [2:0]               last_result;
      logic                     run_begun;
   } saz_rsp_type;

endpackage

// File: src/saz_csr.sv
// saz_csr: configuration registers of the auto-zero sequencer
// depends on saz_pkg; tells the core when to restart from the new values

module saz_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [saz_pkg::MASS_W-1:0] csr_wdata,
   output saz_pkg::saz_cfg_type      cfg,
   output saz_pkg::saz_load_type     load
);
   import saz_pkg::*;

   saz_cfg_type cfg_ff, cfg_in;
   logic        hit;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      if (csr_we) begin
         hit = 1'b1;
         case (csr_index)
            CSR_ENABLED:    cfg_in.boot_enable   = csr_wdata[0];
            CSR_TARE:       cfg_in.tare_restored = csr_wdata[0];
            CSR_TIMEOUT:    cfg_in.timeout_lim   = csr_wdata[TIME_W-1:0];
            CSR_ZERO_RANGE: cfg_in.zero_range    = csr_wdata;
            default:        hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boot_enable   <= 1'b1;
         cfg_ff.tare_restored <= 1'b0;
         cfg_ff.timeout_lim   <= TIMEOUT_DEF;
         cfg_ff.zero_range    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg         = cfg_ff;
   assign load.reinit = hit;
   assign load.next   = cfg_in;

endmodule

// File: src/saz_core.sv
// saz_core: sequencer state and the per-transaction priority checks
// depends on saz_pkg; fed by the top level's input register, feeds its result register

module saz_core #(
   parameter int MASS_BITS = saz_pkg::MASS_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  saz_pkg::saz_cfg_type  cfg,
   input  saz_pkg::saz_load_type load,
   input  logic                  fire,
   input  saz_pkg::saz_req_type  item,
   output saz_pkg::saz_rsp_type  result
);
   import saz_pkg::*;

   logic [3:0]                  phase_ff, phase_in;
   logic                        terminal_ff, terminal_in;
   logic                        pending_ff, pending_in;
   logic                        started_ff, started_in;
   logic [TIME_W-1:0]           start_ff, start_in;
   logic [TIME_W-1:0]           elapsed_ff, elapsed_in;
   logic signed [MASS_BITS-1:0] mass_ff, mass_in;
   logic [2:0]                  last_ff, last_in;
   logic                        zreq;

   logic signed [MASS_BITS-1:0] mass_lo;
   logic [MASS_BITS-1:0]        mag;
   logic                        mass_min;
   logic                        out_of_range;
   logic [TIME_W-1:0]           start_sel;
   logic [TIME_W-1:0]           elapsed_now;

   // range check on the sign-extended low bits of the mass
   assign mass_lo  = item.gross_mass[MASS_BITS-1:0];
   assign mass_min = mass_lo[MASS_BITS-1] && (mass_lo[MASS_BITS-2:0] == '0);
   assign mag      = mass_lo[MASS_BITS-1] ? $unsigned(-mass_lo) : $unsigned(mass_lo);
   assign out_of_range = cfg.zero_range[MASS_W-1] || mass_min ||
                         (MASS_W'(mag) > $unsigned(cfg.zero_range));

   assign start_sel   = started_ff ? start_ff : item.now_ms;
   assign elapsed_now = item.now_ms - start_sel;

   always_comb begin
      phase_in    = phase_ff;
      terminal_in = terminal_ff;
      pending_in  = pending_ff;
      started_in  = started_ff;
      start_in    = start_ff;
      elapsed_in  = elapsed_ff;
      mass_in     = mass_ff;
      last_in     = last_ff;
      zreq        = 1'b0;
      if (fire) begin
         if (item.op == OP_COMPLETE) begin
            if (pending_ff) begin
               last_in     = {1'b0, item.zero_result};
               terminal_in = 1'b1;
               pending_in  = 1'b0;
               case (item.zero_result)
                  ZR_OK:     phase_in = PH_APPLIED;
                  ZR_RANGE:  phase_in = PH_RANGE;
                  ZR_BADCAL: phase_in = PH_BADCAL;
                  default:   phase_in = PH_FAULT;
               endcase
            end
         end else if (!terminal_ff && !pending_ff && item.app_live) begin
            started_in = 1'b1;
            start_in   = start_sel;
            elapsed_in = elapsed_now;
            mass_in    = mass_lo;
            if (item.front_fault) begin
               phase_in    = PH_FAULT;
               terminal_in = 1'b1;
            end else if (!item.cal_ok) begin
               phase_in    = PH_BADCAL;
               terminal_in = 1'b1;
            end else if (elapsed_now >= cfg.timeout_lim) begin
               phase_in    = PH_TIMEOUT;
               terminal_in = 1'b1;
            end else if (!item.meas_ready) begin
               phase_in = PH_WAIT_MEAS;
            end else if (!item.stable) begin
               phase_in = PH_WAIT_STABLE;
            end else if (out_of_range) begin
               phase_in    = PH_RANGE;
               terminal_in = 1'b1;
            end else begin
               pending_in = 1'b1;
               zreq       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || load.reinit) begin
         // restart from the configuration in force after this edge
         pending_ff  <= 1'b0;
         started_ff  <= 1'b0;
         start_ff    <= '0;
         elapsed_ff  <= '0;
         mass_ff     <= '0;
         last_ff     <= LAST_NONE;
         if (reset) begin
            phase_ff    <= PH_WAIT_MEAS;
            terminal_ff <= 1'b0;
         end else if (!load.next.boot_enable) begin
            phase_ff    <= PH_DISABLED;
            terminal_ff <= 1'b1;
         end else if (load.next.tare_restored) begin
            phase_ff    <= PH_TARE;
            terminal_ff <= 1'b1;
         end else begin
            phase_ff    <= PH_WAIT_MEAS;
            terminal_ff <= 1'b0;
         end
      end else begin
         phase_ff    <= phase_in;
         terminal_ff <= terminal_in;
         pending_ff  <= pending_in;
         started_ff  <= started_in;
         start_ff    <= start_in;
         elapsed_ff  <= elapsed_in;
         mass_ff     <= mass_in;
         last_ff     <= last_in;
      end
   end

   assign result.zero_request    = zreq;
   assign result.phase           = phase_in;
   assign result.is_terminal     = terminal_in;
   assign result.request_pending = pending_in;
   assign result.elapsed         = elapsed_in;
   assign result.observed_mass   = MASS_W'(mass_in);
   assign result.last_result     = last_in;
   assign result.run_begun       = started_in;

endmodule

// File: src/startup_auto_zero_sequencer.sv
// startup_auto_zero_sequencer: top level with input and result registers
// depends on saz_pkg, saz_csr and saz_core
//
// usage:
//   req channel (req_valid, req_stall, req_data) carries tick and completion
//   transactions; rsp channel (rsp_valid, rsp_stall, rsp_data) returns exactly
//   one result per transaction, in order, with the state snapshot.
//   csr port (csr_we, csr_index, csr_wdata) writes a register and restarts the
//   sequence from the new configuration; write only while idle.
// a transaction waits in the input register, then passes the check logic into
//   the result register, where rsp_valid rises; while the result register is held,
//   the transaction stays in the input register.
// throughput: one transaction per cycle while the result side does not stall,
//   set by the single state update per cycle in saz_core.
// reset: registers return to their defaults (enabled, no tare, 5000 ms,
//   zero range 0), the sequence waits for a measurement, both stages empty.
// stall: a held result keeps rsp_data steady; the input register still takes
//   one transaction, after which req_stall rises until the result is taken.

module startup_auto_zero_sequencer #(
   parameter int MASS_BITS = saz_pkg::MASS_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  saz_pkg::saz_req_type       req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output saz_pkg::saz_rsp_type       rsp_data,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [saz_pkg::MASS_W-1:0] csr_wdata
);
   import saz_pkg::*;

   saz_cfg_type  cfg;
   saz_load_type load;
   saz_rsp_type  result;
   saz_req_type  item_ff;
   saz_rsp_type  rsp_data_ff;
   logic         item_valid_ff, item_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         fire;
   logic         take;

   // input stage moves on when the result register is free or being emptied
   assign fire      = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !fire;
   assign take      = req_valid && !req_stall;

   assign item_valid_in = take || (item_valid_ff && !fire);
   assign rsp_valid_in  = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   saz_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .load      (load)
   );

   saz_core #(
      .MASS_BITS (MASS_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .load   (load),
      .fire   (fire),
      .item   (item_ff),
      .result (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/saz_checker.sv
// saz_checker: port-level assertions for startup_auto_zero_sequencer
// depends on saz_pkg; attached to the top level by the bind below

module saz_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input saz_pkg::saz_rsp_type rsp_data
);
   import saz_pkg::*;

   // a held result transaction does not move
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a raised zero request leaves the sequence pending and not finished
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_request |->
         rsp_data.request_pending && !rsp_data.is_terminal)
      else $error("zero request without pending state");

   // a finished sequence never has a request outstanding
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_terminal |-> !rsp_data.request_pending)
      else $error("terminal with pending request");

   // only the two waiting phases are not terminal
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_terminal |->
         rsp_data.phase == PH_WAIT_MEAS || rsp_data.phase == PH_WAIT_STABLE)
      else $error("running sequence in a terminal phase");

endmodule

bind startup_auto_zero_sequencer saz_checker u_saz_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: dv/tb_startup_auto_zero_sequencer.sv
// tb_startup_auto_zero_sequencer: self-checking testbench for the startup auto-zero sequencer
// a stimulus table then episodes of random ticks and completions, checked against a scoreboard
// depends on saz_pkg and startup_auto_zero_sequencer

module tb_startup_auto_zero_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import saz_pkg::*;

   localparam int MASS_BITS = MASS_BITS_DEF;
   localparam logic signed [63:0] MASS_MIN = {64{1'b1}} << (MASS_BITS - 1);
   localparam logic signed [63:0] MASS_MAX = ~MASS_MIN;
   localparam int ITEM_TARGET = 1540;
   localparam int CALM_AFTER  = 1450;
   localparam int HOLD_AFTER  = 400;
   localparam int HOLD_CYCLES = 120;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PLAN_ROWS   = 37;

   typedef struct {
      logic        is_write;
      logic [1:0]  idx;
      logic [63:0] wdata;
      saz_req_type item;
      logic        typed;
      saz_rsp_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   saz_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   saz_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_ENABLED;
   logic [63:0] csr_wdata = '0;

   // scoreboard copy of the sequencer
   saz_cfg_type              scale_cfg;
   logic [3:0]               phase_now;
   logic                     is_done;
   logic                     zero_pending;
   logic                     run_seen;
   logic [31:0]              start_ms;
   logic [31:0]              elapsed_cnt;
   logic signed [63:0]       last_mass;
   logic [2:0]               last_code;

   saz_rsp_type snapshot_q[$];
   saz_rsp_type predicted;
   saz_rsp_type expected;
   saz_rsp_type typed_rsp;
   logic        typed_valid = 1'b0;

   int mismatches = 0;
   int sent_items = 0;
   int live_items = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int requests_seen = 0;
   int phase_hits[16];
   int cycle_count = 0;

   // receiver idling
   logic calm = 1'b0;
   logic hold_request = 1'b0;
   int   hold_left = 0;
   int   stall_left = 0;
   int   free_left = 0;

   plan_row_type plan[PLAN_ROWS];

   startup_auto_zero_sequencer #(.MASS_BITS(MASS_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function void enter_final(input logic [3:0] p);
      phase_now = p;
      is_done = 1'b1;
      zero_pending = 1'b0;
   endfunction

   function void restart_sequence();
      phase_now = PH_WAIT_MEAS;
      is_done = 1'b0;
      zero_pending = 1'b0;
      run_seen = 1'b0;
      start_ms = '0;
      elapsed_cnt = '0;
      last_mass = '0;
      last_code = LAST_NONE;
      if (!scale_cfg.boot_enable) enter_final(PH_DISABLED);
      else if (scale_cfg.tare_restored) enter_final(PH_TARE);
   endfunction

   function automatic logic mass_rejected(input logic signed [63:0] m);
      logic signed [63:0] mag;
      if (scale_cfg.zero_range < 0) return 1'b1;
      if (m == MASS_MIN) return 1'b1;
      mag = (m < 0) ? -m : m;
      return mag > scale_cfg.zero_range;
   endfunction

   // returns 1 when the transaction touched the sequence state
   function automatic logic advance_sequence(input saz_req_type t, output saz_rsp_type s);
      logic               raised;
      logic               touched;
      logic signed [63:0] m;
      raised = 1'b0;
      touched = 1'b0;
      if (t.op == OP_COMPLETE) begin
         if (zero_pending) begin
            touched = 1'b1;
            last_code = {1'b0, t.zero_result};
            case (t.zero_result)
               ZR_OK:     enter_final(PH_APPLIED);
               ZR_RANGE:  enter_final(PH_RANGE);
               ZR_BADCAL: enter_final(PH_BADCAL);
               default:   enter_final(PH_FAULT);
            endcase
         end
      end else if (!is_done && !zero_pending && t.app_live) begin
         touched = 1'b1;
         if (!run_seen) begin
            run_seen = 1'b1;
            start_ms = t.now_ms;
         end
         elapsed_cnt = t.now_ms - start_ms;
         m = t.gross_mass;
         m = (m <<< (64 - MASS_BITS)) >>> (64 - MASS_BITS);
         last_mass = m;
         if (t.front_fault) enter_final(PH_FAULT);
         else if (!t.cal_ok) enter_final(PH_BADCAL);
         else if (elapsed_cnt >= scale_cfg.timeout_lim) enter_final(PH_TIMEOUT);
         else if (!t.meas_ready) phase_now = PH_WAIT_MEAS;
         else if (!t.stable) phase_now = PH_WAIT_STABLE;
         else if (mass_rejected(m)) enter_final(PH_RANGE);
         else begin
            zero_pending = 1'b1;
            raised = 1'b1;
         end
      end
      s = '{raised, phase_now, is_done, zero_pending, elapsed_cnt, last_mass, last_code,
            run_seen};
      return touched;
   endfunction

   function void check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
      if (exp_v !== got_v) begin
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, name, exp_v, got_v);
      end
   endfunction

   // scoreboard: registers, accepted transactions and results, all at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
      if (reset) begin
         scale_cfg = '{1'b1, 1'b0, TIMEOUT_DEF, 64'sd0};
         restart_sequence();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLED:    scale_cfg.boot_enable = csr_wdata[0];
               CSR_TARE:       scale_cfg.tare_restored = csr_wdata[0];
               CSR_TIMEOUT:    scale_cfg.timeout_lim = csr_wdata[31:0];
               CSR_ZERO_RANGE: scale_cfg.zero_range = csr_wdata;
               default:        ;
            endcase
            restart_sequence();
            csr_writes++;
         end
         if (req_valid && !req_stall) begin
            sent_items++;
            if (advance_sequence(req_data, predicted)) live_items++;
            snapshot_q.push_back(typed_valid ? typed_rsp : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (snapshot_q.size() == 0) begin
               mismatches++;
               $display("%0t: result with no transaction pending, expected none actual %h",
                        $time, rsp_data);
            end else begin
               expected = snapshot_q.pop_front();
               results_checked++;
               phase_hits[rsp_data.phase]++;
               if (rsp_data.zero_request) requests_seen++;
               check_field("zero_request", expected.zero_request, rsp_data.zero_request);
               check_field("phase", expected.phase, rsp_data.phase);
               check_field("is_terminal", expected.is_terminal, rsp_data.is_terminal);
               check_field("request_pending", expected.request_pending,
                           rsp_data.request_pending);
               check_field("elapsed", expected.elapsed, rsp_data.elapsed);
               check_field("observed_mass", expected.observed_mass, rsp_data.observed_mass);
               check_field("last_result", expected.last_result, rsp_data.last_result);
               check_field("run_begun", expected.run_begun, rsp_data.run_begun);
            end
         end
      end
   end

   // result side: random stall bursts, free stretches, one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            free_left = $urandom_range(30, 90);
            rsp_stall <= 1'b0;
         end else begin
            stall_left = $urandom_range(0, 8);
            free_left = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end
      end
   end

   function automatic saz_rsp_type make_snapshot(input logic zr, input logic [3:0] p,
                                                 input logic term, input logic pend,
                                                 input logic [31:0] el,
                                                 input logic signed [63:0] m,
                                                 input logic [2:0] last, input logic begun);
      make_snapshot = '{zr, p, term, pend, el, m, last, begun};
   endfunction

   function automatic plan_row_type wr(input logic [1:0] idx, input logic [63:0] value);
      wr = '{1'b1, idx, value, '0, 1'b0, '0};
   endfunction

   function automatic plan_row_type tk(input logic [31:0] now, input logic run,
                                       input logic fault, input logic cal,
                                       input logic ready, input logic steady,
                                       input logic signed [63:0] m);
      saz_req_type t;
      t = '{OP_TICK, now, run, fault, cal, ready, steady, m, 2'($urandom)};
      tk = '{1'b0, CSR_ENABLED, '0, t, 1'b0, '0};
   endfunction

   function automatic plan_row_type cp(input logic [1:0] code);
      saz_req_type t;
      t = '{OP_COMPLETE, $urandom, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
            1'($urandom), {$urandom, $urandom}, code};
      cp = '{1'b0, CSR_ENABLED, '0, t, 1'b0, '0};
   endfunction

   function automatic plan_row_type with_want(input plan_row_type r, input saz_rsp_type w);
      with_want = r;
      with_want.typed = 1'b1;
      with_want.want = w;
   endfunction

   function automatic saz_req_type random_completion();
      plan_row_type r;
      r = cp(2'($urandom));
      return r.item;
   endfunction

   function automatic logic signed [63:0] pick_mass();
      logic signed [63:0] r;
      r = scale_cfg.zero_range;
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: return MASS_MAX;
         2: return MASS_MIN;
         3: return $urandom_range(0, 1) ? r : -r;
         4: return $urandom_range(0, 1) ? r + 1 : -r - 1;
         5: return 64'(int'($urandom_range(0, 20)) - 10);
         default: return 64'(int'($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   function automatic int pick_gap();
      if (calm || hold_left > 0 || hold_request) return 0;
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 9);
      return 0;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance with valid still up
   task automatic send_item(input saz_req_type t, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      req_valid <= 1'b0;
      while (snapshot_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      saz_req_type        item;
      logic [1:0]         idx;
      logic [63:0]        value;
      logic [31:0]        stamp;
      int                 ticks;
      logic               hold_used;

      hold_used = 1'b0;
      // directed walk; a few rows carry an expectation typed in by hand
      plan[0]  = with_want(cp(ZR_OK),
                           make_snapshot(0, PH_WAIT_MEAS, 0, 0, 0, 0, LAST_NONE, 0));
      plan[1]  = with_want(tk(100, 0, 0, 1, 1, 1, 64'sd9),
                           make_snapshot(0, PH_WAIT_MEAS, 0, 0, 0, 0, LAST_NONE, 0));
      plan[2]  = with_want(tk(1000, 1, 0, 1, 0, 0, 64'sd5),
                           make_snapshot(0, PH_WAIT_MEAS, 0, 0, 0, 5, LAST_NONE, 1));
      plan[3]  = with_want(tk(1010, 1, 0, 1, 1, 0, -64'sd3),
                           make_snapshot(0, PH_WAIT_STABLE, 0, 0, 10, -3, LAST_NONE, 1));
      plan[4]  = with_want(tk(1020, 1, 0, 1, 1, 1, 64'sd0),
                           make_snapshot(1, PH_WAIT_STABLE, 0, 1, 20, 0, LAST_NONE, 1));
      plan[5]  = with_want(tk(1030, 1, 0, 1, 1, 1, 64'sd0),
                           make_snapshot(0, PH_WAIT_STABLE, 0, 1, 20, 0, LAST_NONE, 1));
      plan[6]  = with_want(cp(ZR_OK),
                           make_snapshot(0, PH_APPLIED, 1, 0, 20, 0, {1'b0, ZR_OK}, 1));
      plan[7]  = tk(1040, 1, 0, 1, 1, 1, 64'sd0);
      plan[8]  = wr(CSR_ZERO_RANGE, MASS_MAX);
      plan[9]  = with_want(tk(32'hFFFF_FFFF, 1, 1, 1, 1, 1, MASS_MAX),
                           make_snapshot(0, PH_FAULT, 1, 0, 0, MASS_MAX, LAST_NONE, 1));
      plan[10] = wr(CSR_TARE, 64'd1);
      plan[11] = with_want(tk(5, 1, 0, 1, 1, 1, 64'sd0),
                           make_snapshot(0, PH_TARE, 1, 0, 0, 0, LAST_NONE, 0));
      plan[12] = wr(CSR_TARE, 64'd0);
      plan[13] = wr(CSR_ENABLED, 64'd0);
      plan[14] = with_want(tk(5, 1, 0, 1, 1, 1, 64'sd0),
                           make_snapshot(0, PH_DISABLED, 1, 0, 0, 0, LAST_NONE, 0));
      plan[15] = wr(CSR_ENABLED, 64'd1);
      plan[16] = tk(7, 1, 0, 0, 1, 1, 64'sd42);
      // zero timeout: first running tick past the fault and calibration checks times out
      plan[17] = wr(CSR_TIMEOUT, 64'd0);
      plan[18] = with_want(tk(9, 1, 0, 1, 1, 1, -64'sd7),
                           make_snapshot(0, PH_TIMEOUT, 1, 0, 0, -7, LAST_NONE, 1));
      plan[19] = wr(CSR_TIMEOUT, 64'h0000_0000_FFFF_FFFF);
      // most negative mass is out of range even with the widest range
      plan[20] = with_want(tk(32'hFFFF_FFF0, 1, 0, 1, 1, 1, MASS_MIN),
                           make_snapshot(0, PH_RANGE, 1, 0, 0, MASS_MIN, LAST_NONE, 1));
      plan[21] = wr(CSR_ZERO_RANGE, {64{1'b1}});
      plan[22] = tk(3, 1, 0, 1, 1, 1, 64'sd0);
      plan[23] = wr(CSR_ZERO_RANGE, 64'd1000);
      plan[24] = wr(CSR_TIMEOUT, 64'd50);
      // start time near the wrap, request after the time stamp rolls over
      plan[25] = tk(32'hFFFF_FFF0, 1, 0, 1, 0, 1, 64'sd1001);
      plan[26] = tk(32'h0000_0020, 1, 0, 1, 1, 1, -64'sd1000);
      plan[27] = cp(ZR_FAILURE);
      plan[28] = wr(CSR_TIMEOUT, 64'd50);
      plan[29] = tk(100, 1, 0, 1, 0, 1, 64'sd0);
      plan[30] = tk(150, 1, 0, 1, 1, 1, 64'sd0);
      plan[31] = wr(CSR_ENABLED, 64'd1);
      plan[32] = tk(0, 1, 0, 1, 1, 1, 64'sd1000);
      plan[33] = cp(ZR_RANGE);
      plan[34] = wr(CSR_ENABLED, 64'd1);
      plan[35] = tk(0, 1, 0, 1, 1, 1, 64'sd0);
      plan[36] = cp(ZR_BADCAL);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            write_reg(plan[i].idx, plan[i].wdata);
         end else begin
            typed_valid = plan[i].typed;
            typed_rsp = plan[i].want;
            send_item(plan[i].item, pick_gap());
            typed_valid = 1'b0;
         end
      end

      // episodes: one register write restarts the sequence, then a run of ticks
      while (sent_items < ITEM_TARGET) begin
         calm = (sent_items >= CALM_AFTER);
         idx = 2'($urandom_range(0, 3));
         if (!scale_cfg.boot_enable) idx = CSR_ENABLED;
         else if (scale_cfg.tare_restored) idx = CSR_TARE;
         value = {$urandom, $urandom};
         case (idx)
            CSR_ENABLED: value[0] = ($urandom_range(0, 9) != 0);
            CSR_TARE:    value[0] = ($urandom_range(0, 9) == 0);
            CSR_TIMEOUT: begin
               case ($urandom_range(0, 19))
                  0, 1:    value[31:0] = '0;
                  2:       value[31:0] = 32'd1;
                  3, 4:    value[31:0] = 32'hFFFF_FFFF;
                  5:       value[31:0] = $urandom;
                  6, 7:    value[31:0] = $urandom_range(2, 40);
                  default: value[31:0] = $urandom_range(200, 5000);
               endcase
            end
            default: begin
               case ($urandom_range(0, 19))
                  0, 1, 2: value = {64{1'b1}};
                  3, 4, 5: value = MASS_MAX;
                  6, 7:    value = '0;
                  8, 9:    value = {$urandom, $urandom};
                  default: value = 64'($urandom_range(0, 200000));
               endcase
            end
         endcase
         write_reg(idx, value);
         // long hold-off starts once the sequencer is idle, so the ticks below pile up
         if (!hold_used && sent_items >= HOLD_AFTER) begin
            hold_used = 1'b1;
            hold_request = 1'b1;
         end

         stamp = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FF00 | 32'($urandom_range(0, 255)))
                                             : 32'($urandom);
         ticks = $urandom_range(2, 10);
         for (int k = 0; k < ticks; k++) begin
            item.op = OP_TICK;
            item.now_ms = stamp;
            item.app_live = ($urandom_range(0, 9) != 0);
            item.front_fault = ($urandom_range(0, 39) == 0);
            item.cal_ok = ($urandom_range(0, 29) != 0);
            item.meas_ready = ($urandom_range(0, 4) != 0);
            item.stable = ($urandom_range(0, 3) != 0);
            item.gross_mass = pick_mass();
            item.zero_result = 2'($urandom);
            send_item(item, pick_gap());
            stamp += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6000)
                                                 : $urandom_range(0, 40);
            // stray completion in the middle of a run
            if ($urandom_range(0, 11) == 0) send_item(random_completion(), pick_gap());
         end
         if ($urandom_range(0, 6) != 0) send_item(random_completion(), pick_gap());
      end

      req_valid <= 1'b0;
      while (snapshot_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (snapshot_q.size() != 0) begin
         mismatches++;
         $display("%0t: %0d results never arrived", $time, snapshot_q.size());
      end

      $display("run: %0d transactions sent, %0d results checked, %0d changed the state",
               sent_items, results_checked, live_items);
      $display("     %0d register writes, %0d zero requests, one long receiver hold-off",
               csr_writes, requests_seen);
      $display("phases: wait_meas %0d wait_stable %0d disabled %0d tare %0d fault %0d",
               phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3], phase_hits[4]);
      $display("        badcal %0d timeout %0d range %0d applied %0d",
               phase_hits[5], phase_hits[6], phase_hits[7], phase_hits[8]);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
